/* rtl/mcct_pkg.sv */
package mcct_pkg;

  // table geometry
  localparam int TIME_BITS  = 6;
  localparam int FRAG_BITS  = 3;
  localparam int CELL_BITS  = TIME_BITS + FRAG_BITS;
  localparam int CELLS      = 1 << CELL_BITS;

  // field widths
  localparam int Q_BITS     = 17;
  localparam int N_BITS     = 21;
  localparam int SUM_BITS   = 40;
  localparam int SQ_BITS    = 56;
  localparam int COV_BITS   = 26;
  localparam int ROOT_BITS  = SQ_BITS / 2;
  localparam int SREM_BITS  = ROOT_BITS + 2;

  // serial divider sizing
  localparam int DIV_BITS   = 56;
  localparam int DCNT_BITS  = 6;

  localparam logic [Q_BITS-1:0]   ONE_FX  = 17'd65536;
  localparam logic [N_BITS-1:0]   N_MAX   = 21'd1048576;
  localparam logic [COV_BITS-1:0] COV_MAX = {COV_BITS{1'b1}};
  localparam logic [COV_BITS-1:0] THR_RST = 26'd6554;

  localparam logic FUNC_ACC   = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  // one table cell as stored in RAM
  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic [SQ_BITS-1:0]  sq;
    logic                done;
    logic [Q_BITS-1:0]   hmean;
    logic [N_BITS-1:0]   hcount;
  } cell_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/mcct_ram.sv */
module mcct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mcct_div.sv */
module mcct_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [mcct_pkg::DIV_BITS-1:0]   dividend,
  input  logic [mcct_pkg::N_BITS-1:0]     divisor,
  output mcct_pkg::div_stat_t             stat,
  output logic [mcct_pkg::DIV_BITS-1:0]   quotient
);

  logic [mcct_pkg::DIV_BITS-1:0]  quo;
  logic [mcct_pkg::N_BITS-1:0]    rem;
  logic [mcct_pkg::N_BITS-1:0]    dsr;
  logic [mcct_pkg::DCNT_BITS-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [mcct_pkg::N_BITS:0]      trial;
  logic                           qbit;
  logic [mcct_pkg::N_BITS:0]      diff;

  // restoring step: one quotient bit per cycle
  always_comb begin
    trial = {rem, quo[mcct_pkg::DIV_BITS-1]};
    diff  = trial - {1'b0, dsr};
    qbit  = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == mcct_pkg::DCNT_BITS'(mcct_pkg::DIV_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dsr <= divisor;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      quo <= {quo[mcct_pkg::DIV_BITS-2:0], qbit};
      rem <= qbit ? diff[mcct_pkg::N_BITS-1:0] : trial[mcct_pkg::N_BITS-1:0];
      cnt <= cnt + 1'b1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

/* rtl/mc_cov_convergence_table.sv */
// Monte Carlo mean / coefficient-of-variation table, 64 time points by 8
// fragility columns. An accumulate word (func 0) adds q and q squared to a
// cell and gives no result; it passes through a read state and an update
// state before the next word is accepted. A check word (func 1) gives one
// result word with the mean, the cov of the mean and the converged flag,
// plus the cell's latched mean and count; unless the cell sum is zero it
// makes three 56-step passes through the shared bit-serial divider, a
// 28-step square root and, unless the mean is zero, a final 56-step divide
// for cov. After reset all 512 table cells are cleared one cell per cycle
// while in_stall is high; threshold writes are taken at any time.
module mc_cov_convergence_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [25:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [5:0]  time_index,
  input  logic [2:0]  fragility_index,
  input  logic [16:0] sample_value,
  input  logic [20:0] sample_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] mean_estimate,
  output logic [25:0] cov_estimate,
  output logic        converged_now,
  output logic [16:0] latched_mean,
  output logic [20:0] latched_count
);

  typedef enum logic [10:0] {
    S_CLR   = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_RD    = 11'b00000000100,
    S_UPD   = 11'b00000001000,
    S_DIVS  = 11'b00000010000,
    S_DIVS2 = 11'b00000100000,
    S_DIVD  = 11'b00001000000,
    S_SQRT  = 11'b00010000000,
    S_COVS  = 11'b00100000000,
    S_DIVC  = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [mcct_pkg::COV_BITS-1:0]  threshold;
  logic [mcct_pkg::CELL_BITS:0]   clr_cnt;

  logic                           item_func;
  logic [mcct_pkg::CELL_BITS-1:0] item_cell;
  logic [mcct_pkg::Q_BITS-1:0]    item_q;
  logic [mcct_pkg::N_BITS-1:0]    item_n;

  mcct_pkg::cell_t                rdata;
  mcct_pkg::cell_t                cellr;
  mcct_pkg::cell_t                wdata;
  logic                           ram_we;
  logic [mcct_pkg::CELL_BITS-1:0] waddr;

  logic [2*mcct_pkg::Q_BITS-1:0]  sq_prod;
  logic [mcct_pkg::Q_BITS-1:0]    m;
  logic [2*mcct_pkg::Q_BITS-1:0]  msq;
  logic [mcct_pkg::SQ_BITS-1:0]   vsh;
  logic [mcct_pkg::SREM_BITS-1:0] sq_rem;
  logic [mcct_pkg::ROOT_BITS-1:0] root;
  logic [4:0]                     sq_cnt;
  logic [mcct_pkg::COV_BITS-1:0]  cov;

  logic                           div_start;
  logic [mcct_pkg::DIV_BITS-1:0]  div_a;
  logic [mcct_pkg::N_BITS-1:0]    div_b;
  mcct_pkg::div_stat_t            div_st;
  logic [mcct_pkg::DIV_BITS-1:0]  div_q;

  logic                           accept;
  logic                           out_free;
  logic                           fin_go;
  logic [mcct_pkg::Q_BITS-1:0]    qc;
  logic [mcct_pkg::N_BITS-1:0]    nc;
  logic [mcct_pkg::Q_BITS-1:0]    m_c;
  logic [mcct_pkg::SUM_BITS:0]    sum_add;
  logic [mcct_pkg::SQ_BITS:0]     sq_add;
  logic [mcct_pkg::SREM_BITS+1:0] rem_sh;
  logic [mcct_pkg::SREM_BITS+1:0] sq_trial;
  logic                           sq_ok;
  logic                           conv;
  logic                           fin_sq_done;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign fin_go   = (state == S_FIN) && out_free;

  // input clamps
  always_comb begin
    qc = (sample_value > mcct_pkg::ONE_FX) ? mcct_pkg::ONE_FX : sample_value;
    if (sample_count == '0) begin
      nc = mcct_pkg::N_BITS'(1);
    end else if (sample_count > mcct_pkg::N_MAX) begin
      nc = mcct_pkg::N_MAX;
    end else begin
      nc = sample_count;
    end
  end

  // table RAM
  mcct_ram #(
    .WIDTH ($bits(mcct_pkg::cell_t)),
    .DEPTH (mcct_pkg::CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr ({time_index, fragility_index}),
    .rdata (rdata)
  );

  // shared serial divider
  mcct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .stat     (div_st),
    .quotient (div_q)
  );

  // saturating sums, sqrt step, convergence test
  always_comb begin
    sum_add  = {1'b0, cellr.sum} + mcct_pkg::SUM_BITS'(item_q) + (mcct_pkg::SUM_BITS+1)'(0);
    sq_add   = {1'b0, cellr.sq} + mcct_pkg::SQ_BITS'(sq_prod) + (mcct_pkg::SQ_BITS+1)'(0);
    m_c      = (div_q > mcct_pkg::DIV_BITS'(mcct_pkg::ONE_FX)) ? mcct_pkg::ONE_FX
             : div_q[mcct_pkg::Q_BITS-1:0];
    rem_sh   = {sq_rem, vsh[mcct_pkg::SQ_BITS-1 -: 2]};
    sq_trial = {2'b00, root, 2'b01};
    sq_ok    = (rem_sh >= sq_trial);
    conv     = (cov != '0) && (cov < threshold);
    fin_sq_done = (sq_cnt == 5'(mcct_pkg::ROOT_BITS - 1));
  end

  // RAM write mux
  always_comb begin
    ram_we = 1'b0;
    waddr  = item_cell;
    wdata  = cellr;
    unique case (state)
      S_CLR: begin
        ram_we = 1'b1;
        waddr  = clr_cnt[mcct_pkg::CELL_BITS-1:0];
        wdata  = '0;
      end
      S_UPD: begin
        ram_we    = 1'b1;
        wdata.sum = sum_add[mcct_pkg::SUM_BITS] ? {mcct_pkg::SUM_BITS{1'b1}}
                  : sum_add[mcct_pkg::SUM_BITS-1:0];
        wdata.sq  = sq_add[mcct_pkg::SQ_BITS] ? {mcct_pkg::SQ_BITS{1'b1}}
                  : sq_add[mcct_pkg::SQ_BITS-1:0];
      end
      S_FIN: begin
        ram_we = out_free;
        if (!cellr.done) begin
          wdata.hmean  = m;
          wdata.hcount = item_n;
        end
        wdata.done = cellr.done | conv;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // divider launch
  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = item_n;
    unique case (state)
      S_RD: begin
        div_start = (item_func == mcct_pkg::FUNC_CHECK) && (rdata.sum != '0);
        div_a     = mcct_pkg::DIV_BITS'(rdata.sum);
      end
      S_DIVS: begin
        div_start = div_st.done;
        div_a     = cellr.sq;
      end
      S_DIVS2: begin
        div_start = div_st.done;
        div_a     = (div_q > mcct_pkg::DIV_BITS'(msq))
                  ? div_q - mcct_pkg::DIV_BITS'(msq) : '0;
      end
      S_COVS: begin
        div_start = (m != '0);
        div_a     = mcct_pkg::DIV_BITS'({root, 16'h0000});
        div_b     = mcct_pkg::N_BITS'(m);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:   if (clr_cnt == (mcct_pkg::CELL_BITS+1)'(mcct_pkg::CELLS - 1)) begin
                 state_next = S_IDLE;
               end
      S_IDLE:  if (accept) begin
                 state_next = S_RD;
               end
      S_RD: begin
        if (item_func == mcct_pkg::FUNC_ACC) begin
          state_next = S_UPD;
        end else if (rdata.sum == '0) begin
          state_next = S_FIN;
        end else begin
          state_next = S_DIVS;
        end
      end
      S_UPD:   state_next = S_IDLE;
      S_DIVS:  if (div_st.done) begin
                 state_next = S_DIVS2;
               end
      S_DIVS2: if (div_st.done) begin
                 state_next = S_DIVD;
               end
      S_DIVD:  if (div_st.done) begin
                 state_next = S_SQRT;
               end
      S_SQRT:  if (fin_sq_done) begin
                 state_next = S_COVS;
               end
      S_COVS:  state_next = (m == '0) ? S_FIN : S_DIVC;
      S_DIVC:  if (div_st.done) begin
                 state_next = S_FIN;
               end
      S_FIN:   if (out_free) begin
                 state_next = S_IDLE;
               end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      threshold <= mcct_pkg::THR_RST;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_func <= func;
      item_cell <= {time_index, fragility_index};
      item_q    <= qc;
      item_n    <= nc;
    end
    if (state == S_RD) begin
      cellr   <= rdata;
      sq_prod <= item_q * item_q;
      m       <= '0;
      cov     <= '0;
    end
    // mean and its square
    if (state == S_DIVS && div_st.done) begin
      m   <= m_c;
      msq <= m_c * m_c;
    end
    // square root, two radicand bits per cycle
    if (state == S_DIVD && div_st.done) begin
      vsh    <= div_q;
      sq_rem <= '0;
      root   <= '0;
      sq_cnt <= '0;
    end
    if (state == S_SQRT) begin
      vsh    <= {vsh[mcct_pkg::SQ_BITS-3:0], 2'b00};
      sq_rem <= sq_ok ? mcct_pkg::SREM_BITS'(rem_sh - sq_trial)
              : mcct_pkg::SREM_BITS'(rem_sh);
      root   <= {root[mcct_pkg::ROOT_BITS-2:0], sq_ok};
      sq_cnt <= sq_cnt + 1'b1;
    end
    if (state == S_COVS && m == '0) begin
      cov <= mcct_pkg::COV_MAX;
    end
    if (state == S_DIVC && div_st.done) begin
      cov <= (div_q > mcct_pkg::DIV_BITS'(mcct_pkg::COV_MAX)) ? mcct_pkg::COV_MAX
           : div_q[mcct_pkg::COV_BITS-1:0];
    end
    // result word
    if (fin_go) begin
      mean_estimate <= m;
      cov_estimate  <= cov;
      converged_now <= conv;
      latched_mean  <= cellr.done ? cellr.hmean : m;
      latched_count <= cellr.done ? cellr.hcount : item_n;
    end
  end

  // checks
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider restarted while busy");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLR || state == S_UPD || state == S_FIN))
    else $error("table write outside a write state");

  a_conv_cov: assert property (@(posedge clk) disable iff (rst)
    (out_valid && converged_now) |-> (cov_estimate != '0))
    else $error("converged with zero cov");

endmodule

/* tb/mcct_checker.sv */
// Watches both channels, predicts each check result and compares.
module mcct_checker
  import mcct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [25:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        func,
  input  logic [5:0]  time_index,
  input  logic [2:0]  fragility_index,
  input  logic [16:0] sample_value,
  input  logic [20:0] sample_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [16:0] mean_estimate,
  input  logic [25:0] cov_estimate,
  input  logic        converged_now,
  input  logic [16:0] latched_mean,
  input  logic [20:0] latched_count,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [16:0] mean;
    logic [25:0] cov;
    logic        conv;
    logic [16:0] hmean;
    logic [20:0] hcount;
  } check_word_t;

  logic [25:0] thr;
  logic [63:0] sums [CELLS];
  logic [63:0] sqsums [CELLS];
  logic        done_f [CELLS];
  logic [16:0] hmean_m [CELLS];
  logic [20:0] hcount_m [CELLS];
  check_word_t expected_q [$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x) r = r | (64'd1 << b);
    return r;
  endfunction

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] top);
    return (a + b > top) ? top : a + b;
  endfunction

  // model one accepted word
  task automatic apply_word();
    int c;
    logic [63:0] q, n, s, s2, m, ms, msq, d, sd, cov;
    check_word_t w;
    c = {time_index, fragility_index};
    if (func == FUNC_ACC) begin
      q = sample_value;
      if (q > ONE_FX) q = ONE_FX;
      sums[c] = sat_sum(sums[c], q, (64'd1 << 40) - 1);
      sqsums[c] = sat_sum(sqsums[c], q * q, (64'd1 << 56) - 1);
      return;
    end
    n = sample_count;
    if (n == 0) n = 1;
    if (n > N_MAX) n = N_MAX;
    s = sums[c];
    s2 = sqsums[c];
    m = 0;
    cov = 0;
    if (s > 0) begin
      m = s / n;
      if (m > ONE_FX) m = ONE_FX;
      ms = s2 / n;
      msq = m * m;
      d = (ms > msq) ? ms - msq : 0;
      sd = int_sqrt(d / n);
      if (m == 0) cov = COV_MAX;
      else begin
        cov = (sd << 16) / m;
        if (cov > COV_MAX) cov = COV_MAX;
      end
    end
    if (!done_f[c]) begin
      hmean_m[c] = m;
      hcount_m[c] = n;
    end
    w.conv = (cov > 0 && cov < thr);
    if (w.conv) done_f[c] = 1;
    w.mean = m;
    w.cov = cov;
    w.hmean = hmean_m[c];
    w.hcount = hcount_m[c];
    expected_q.push_back(w);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      thr <= THR_RST;
      fail_count = 0;
      pending <= 0;
      for (int i = 0; i < CELLS; i++) begin
        sums[i] = 0; sqsums[i] = 0; done_f[i] = 0; hmean_m[i] = 0; hcount_m[i] = 0;
      end
    end else begin
      if (cfg_we) thr <= cfg_wdata;
      if (in_valid && !in_stall) apply_word();
      // compare result word against oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word");
          fail_count = fail_count + 1;
        end else begin
          check_word_t e;
          e = expected_q.pop_front();
          if (e.mean !== mean_estimate) begin
            $error("mean_estimate exp %0d got %0d", e.mean, mean_estimate);
            fail_count = fail_count + 1;
          end
          if (e.cov !== cov_estimate) begin
            $error("cov_estimate exp %0d got %0d", e.cov, cov_estimate);
            fail_count = fail_count + 1;
          end
          if (e.conv !== converged_now) begin
            $error("converged_now exp %0d got %0d", e.conv, converged_now);
            fail_count = fail_count + 1;
          end
          if (e.hmean !== latched_mean) begin
            $error("latched_mean exp %0d got %0d", e.hmean, latched_mean);
            fail_count = fail_count + 1;
          end
          if (e.hcount !== latched_count) begin
            $error("latched_count exp %0d got %0d", e.hcount, latched_count);
            fail_count = fail_count + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

/* tb/tb_mc_cov_convergence_table.sv */
module tb_mc_cov_convergence_table;
  import mcct_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [25:0] cfg_wdata = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        func = 0;
  logic [5:0]  time_index = 0;
  logic [2:0]  fragility_index = 0;
  logic [16:0] sample_value = 0;
  logic [20:0] sample_count = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [16:0] mean_estimate;
  logic [25:0] cov_estimate;
  logic        converged_now;
  logic [16:0] latched_mean;
  logic [20:0] latched_count;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic [5:0]  hot_t;
  logic [2:0]  hot_f;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  mc_cov_convergence_table u_top (.*);

  mcct_checker u_chk (.*);

  // receiver stall
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < recv_idle_pct);

  // send one word, with random gap before it; valid stays up for the next word
  task automatic send_word(input logic f, input logic [5:0] t, input logic [2:0] fr,
                           input logic [16:0] q, input logic [20:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    func <= f;
    time_index <= t;
    fragility_index <= fr;
    sample_value <= q;
    sample_count <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_thr(input logic [25:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // random phase: mostly bursts of samples into one cell followed by checks
  task automatic random_phase(input int words);
    int k;
    logic [20:0] n;
    k = 0;
    while (k < words) begin
      hot_t = 6'($urandom);
      hot_f = 3'($urandom);
      n = 0;
      repeat ($urandom_range(12, 1)) begin
        send_word(FUNC_ACC, hot_t, hot_f,
                  ($urandom_range(9) == 0) ? 17'($urandom) :
                  17'($urandom_range(40000, 20000)), 21'($urandom));
        n++;
        k++;
      end
      send_word(FUNC_CHECK, hot_t, hot_f, 17'($urandom),
                ($urandom_range(7) == 0) ? 21'($urandom) : n);
      k++;
      if ($urandom_range(3) == 0) begin
        send_word(1'($urandom), 6'($urandom), 3'($urandom), 17'($urandom), 21'($urandom));
        k++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    // directed: extremes, zero sum, tiny mean, saturated mean, zero count, big count
    send_word(FUNC_CHECK, 0, 0, 0, 0);
    send_word(FUNC_ACC, 63, 7, 17'h1FFFF, 0);
    send_word(FUNC_ACC, 63, 7, 65536, 0);
    send_word(FUNC_CHECK, 63, 7, 0, 1);
    send_word(FUNC_CHECK, 63, 7, 0, 21'h1FFFFF);
    send_word(FUNC_CHECK, 63, 7, 0, 21'd1048576);
    send_word(FUNC_ACC, 1, 2, 1, 0);
    send_word(FUNC_CHECK, 1, 2, 0, 1000);
    send_word(FUNC_ACC, 2, 3, 30000, 0);
    send_word(FUNC_ACC, 2, 3, 30010, 0);
    send_word(FUNC_ACC, 2, 3, 29990, 0);
    send_word(FUNC_CHECK, 2, 3, 0, 3);
    send_word(FUNC_CHECK, 2, 3, 0, 0);
    send_word(FUNC_ACC, 3, 4, 0, 0);
    send_word(FUNC_ACC, 3, 4, 65535, 0);
    send_word(FUNC_CHECK, 3, 4, 0, 2);
    write_thr(26'h3FFFFFF);
    send_word(FUNC_CHECK, 3, 4, 0, 2);
    send_word(FUNC_CHECK, 3, 4, 0, 5);
    write_thr(0);
    send_word(FUNC_CHECK, 2, 3, 0, 3);
    write_thr(THR_RST);

    send_idle_pct = 31; recv_idle_pct = 48;
    random_phase(200);
    write_thr(26'($urandom_range(200000)));
    send_idle_pct = 48; recv_idle_pct = 31;
    random_phase(200);
    write_thr(26'($urandom));
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(200);
    drain();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #8000000;
    $display("tb: failure");
    $finish;
  end

endmodule
